// ===== hdl/lru_write_back_cache_assert.svh =====
// Assertion helpers shared by the cache RTL.
`ifndef LRU_WRITE_BACK_CACHE_ASSERT_SVH
`define LRU_WRITE_BACK_CACHE_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LWBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lwbc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LWBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lwbc assertion failed");

`else

`define LWBC_ASSERT_SAME(label, clk, rst, ante, cons)
`define LWBC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/lwbc_pkg.sv =====
`default_nettype none

package lwbc_pkg;

   // Cache and backing memory geometry.
   localparam int CACHE_DEPTH = 8;
   localparam int POS_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(CACHE_DEPTH + 1);
   localparam int MEM_DEPTH   = 1024;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);

   // Field widths.
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 32;
   localparam int MEMW_W     = 11;
   localparam int CENT_W     = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_MEMORY_WORDS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_ENTRIES = CSR_IDX_W'(1);
   localparam logic [MEMW_W-1:0]    MEM_WORDS_RESET     = MEMW_W'(1024);
   localparam logic [CENT_W-1:0]    CACHE_ENTRIES_RESET = CENT_W'(8);

   // Operation codes.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Status codes.
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_OOB  = 1'b1;

   // One cached word.
   typedef struct packed {
      logic [MEM_AW-1:0]        addr;
      logic signed [DATA_W-1:0] data;
   } entry_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic              shift;
      logic [MEM_AW-1:0] key;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/lwbc_channels.sv =====
`default_nettype none

// Request channel: one read or write per transfer.
interface lwbc_req_if import lwbc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [ADDR_W-1:0]        address;
   logic signed [DATA_W-1:0] wdata;

   modport source (output valid, output op, output address, output wdata, input ready);
   modport sink   (input valid, input op, input address, input wdata, output ready);
endinterface

// Response channel: one result per request.
interface lwbc_rsp_if import lwbc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] rdata;
   logic                     status;
   logic                     hit;

   modport source (output valid, output rdata, output status, output hit, input ready);
   modport sink   (input valid, input rdata, input status, input hit, output ready);
endinterface

// Register write channel.
interface lwbc_csr_if import lwbc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/lwbc_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module lwbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lwbc_cell.sv =====
`default_nettype none

// One recency position of the cache. On a shift it takes the entry of the
// more recent neighbor; it always compares its address with the lookup key.
module lwbc_cell import lwbc_pkg::*; (
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    prev_entry,
   output entry_type         entry,
   output logic              match
);

   entry_type entry_ff;
   entry_type entry_in;

   // Shift from the neighbor or hold.
   always_comb begin
      entry_in = ctl.shift ? prev_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff.addr == ctl.key);

endmodule

`default_nettype wire

// ===== hdl/lru_write_back_cache.sv =====
// Flow: a request transfer moves the sequencer from idle to lookup, where the
// registered read of the backing RAM and the recency chain give the result; it is
// registered once the output is free, and only then is a new request taken.
// Reset: synchronous; a clearing pass then writes zeros to all 1024 backing
// words, one per cycle, with req_bus.ready low; register writes are taken.
`default_nettype none

`include "lru_write_back_cache_assert.svh"

module lru_write_back_cache import lwbc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   lwbc_req_if.sink    req_bus,
   lwbc_rsp_if.source  rsp_bus,
   lwbc_csr_if.sink    csr_bus
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [MEM_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [MEMW_W-1:0]        memory_words_ff, memory_words_in;
   logic [CENT_W-1:0]        cache_entries_ff, cache_entries_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic                     op_ff, op_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic signed [DATA_W-1:0] wdata_ff, wdata_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic                     rsp_hit_ff, rsp_hit_in;

   logic                     req_xfer;
   logic                     out_free;
   logic [MEMW_W-1:0]        mem_limit;
   logic [FILL_W-1:0]        cache_limit;
   logic                     in_bound;
   logic                     full;
   logic [CACHE_DEPTH-1:0]   cell_match;
   logic [CACHE_DEPTH-1:0]   hit_vec;
   logic                     any_hit;
   logic [POS_W-1:0]         hit_pos;
   logic [POS_W-1:0]         target_pos;
   entry_type                target_entry;
   entry_type                front_entry;
   entry_type                cell_entry [CACHE_DEPTH];
   cell_ctl_type             cell_ctl [CACHE_DEPTH];
   logic                     do_update;
   logic                     evict;
   logic                     mem_we;
   logic [MEM_AW-1:0]        mem_waddr;
   logic [DATA_W-1:0]        mem_wdata;
   logic [DATA_W-1:0]        mem_rdata;

   // Handshakes.
   assign req_xfer       = req_bus.valid && req_bus.ready;
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign csr_bus.ready  = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;

   // Effective limits from the configuration registers.
   always_comb begin
      if (memory_words_ff > MEMW_W'(MEM_DEPTH)) begin
         mem_limit = MEMW_W'(MEM_DEPTH);
      end else begin
         mem_limit = memory_words_ff;
      end
      if (cache_entries_ff == '0) begin
         cache_limit = FILL_W'(1);
      end else if (int'(cache_entries_ff) > CACHE_DEPTH) begin
         cache_limit = FILL_W'(CACHE_DEPTH);
      end else begin
         cache_limit = FILL_W'(cache_entries_ff);
      end
   end

   assign in_bound = (addr_ff < ADDR_W'(mem_limit));
   assign full     = (fill_ff >= cache_limit);

   // Recency chain: position 0 is the most recent entry.
   for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
      entry_type prev;
      if (i == 0) begin : g_head
         assign prev = front_entry;
      end else begin : g_body
         assign prev = cell_entry[i-1];
      end
      assign cell_ctl[i].shift = do_update && (POS_W'(i) <= target_pos);
      assign cell_ctl[i].key   = addr_ff[MEM_AW-1:0];
      assign hit_vec[i]        = cell_match[i] && (FILL_W'(i) < fill_ff);

      lwbc_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .prev_entry (prev),
         .entry      (cell_entry[i]),
         .match      (cell_match[i])
      );
   end

   // First matching filled position.
   always_comb begin
      hit_pos = '0;
      for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_pos = POS_W'(i);
         end
      end
   end
   assign any_hit = |hit_vec;

   // Position that is replaced: the hit, the next free cell, or the victim.
   always_comb begin
      if (any_hit) begin
         target_pos = hit_pos;
      end else if (!full) begin
         target_pos = POS_W'(fill_ff);
      end else begin
         target_pos = POS_W'(fill_ff - FILL_W'(1));
      end
      target_entry = cell_entry[target_pos];
   end

   // New most-recent entry.
   always_comb begin
      front_entry.addr = addr_ff[MEM_AW-1:0];
      if (op_ff == OP_WRITE) begin
         front_entry.data = wdata_ff;
      end else if (any_hit) begin
         front_entry.data = target_entry.data;
      end else begin
         front_entry.data = mem_rdata;
      end
   end

   assign do_update = (state_ff == ST_LOOKUP) && out_free && in_bound;
   assign evict     = do_update && !any_hit && full;

   // Backing memory port: clearing pass or write-back of the victim.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = evict;
         mem_waddr = target_entry.addr;
         mem_wdata = target_entry.data;
      end
   end

   lwbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_xfer),
      .rd_addr (req_bus.address[MEM_AW-1:0]),
      .rd_data (mem_rdata)
   );

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + MEM_AW'(1);
            if (clr_cnt_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Request capture, fill count and register writes.
   always_comb begin
      op_in    = req_xfer ? req_bus.op      : op_ff;
      addr_in  = req_xfer ? req_bus.address : addr_ff;
      wdata_in = req_xfer ? req_bus.wdata   : wdata_ff;
      fill_in  = (do_update && !any_hit && !full) ? fill_ff + FILL_W'(1) : fill_ff;

      memory_words_in  = memory_words_ff;
      cache_entries_in = cache_entries_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         if (csr_bus.index == CSR_MEMORY_WORDS) begin
            memory_words_in = csr_bus.data[MEMW_W-1:0];
         end else if (csr_bus.index == CSR_CACHE_ENTRIES) begin
            cache_entries_in = csr_bus.data[CENT_W-1:0];
         end
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_LOOKUP) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_rdata_in  = (in_bound && (op_ff == OP_READ)) ? front_entry.data : '0;
         rsp_status_in = in_bound ? STATUS_DONE : STATUS_OOB;
         rsp_hit_in    = in_bound && any_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_cnt_ff       <= '0;
         memory_words_ff  <= MEM_WORDS_RESET;
         cache_entries_ff <= CACHE_ENTRIES_RESET;
         fill_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_cnt_ff       <= clr_cnt_in;
         memory_words_ff  <= memory_words_in;
         cache_entries_ff <= cache_entries_in;
         fill_ff          <= fill_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      wdata_ff      <= wdata_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.rdata  = rsp_rdata_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.hit    = rsp_hit_ff;

   // The fill count never passes the number of cells.
   `LWBC_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, int'(fill_ff) <= CACHE_DEPTH)
   // A request transfer is always followed by a lookup cycle.
   `LWBC_ASSERT_NEXT(a_lookup_follows, clock, reset, req_xfer, state_ff == ST_LOOKUP)
   // Only a miss on a full cache writes back to memory.
   `LWBC_ASSERT_SAME(a_evict_cause, clock, reset,
      mem_we && (state_ff != ST_CLEAR), do_update && !any_hit && full)
   // An out-of-bound result carries neither data nor a hit.
   `LWBC_ASSERT_SAME(a_oob_result, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_OOB), !rsp_hit_ff && (rsp_rdata_ff == '0))
   // The fill count grows only on an accepted miss.
   `LWBC_ASSERT_NEXT(a_fill_step, clock, reset,
      state_ff != ST_LOOKUP, $stable(fill_ff))

endmodule

`default_nettype wire
